// ----- rtl/core/twcw_pkg.sv -----
// Shared types and constants for the text window character writer.
// No dependencies; the files that use it refer to it by scoped names.
package twcw_pkg;

    localparam logic [2:0] CMD_WRITE = 3'd0;
    localparam logic [2:0] CMD_HOME  = 3'd1;
    localparam logic [2:0] CMD_CLRL  = 3'd2;
    localparam logic [2:0] CMD_CLRW  = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    localparam logic [6:0] CH_BS    = 7'h08;
    localparam logic [6:0] CH_TAB   = 7'h09;
    localparam logic [6:0] CH_NL    = 7'h0A;
    localparam logic [6:0] CH_CR    = 7'h0D;
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_QMARK = 7'h3F;
    localparam logic [6:0] CH_AT    = 7'h40;
    localparam logic [6:0] CH_CARET = 7'h5E;
    localparam logic [6:0] CH_DEL   = 7'h7F;

    localparam logic [2:0] CFG_COLS   = 3'd0;
    localparam logic [2:0] CFG_ROWS   = 3'd1;
    localparam logic [2:0] CFG_TAB    = 3'd2;
    localparam logic [2:0] CFG_SCROLL = 3'd3;
    localparam logic [2:0] CFG_NOWRAP = 3'd4;
    localparam logic [2:0] CFG_HIDE   = 3'd5;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_GLYPH, ST_TMOD, ST_NL,
        ST_SCR_RD, ST_SCR_WR, ST_BLANK, ST_READ, ST_DONE
    } t_state;

    // What a row blank hands over to when its span is done.
    typedef enum logic [2:0] {
        CT_DONE, CT_NL, CT_WIN, CT_SCR_NL, CT_SCR_GL
    } t_cont;

    typedef struct packed {
        logic [7:0] cols;
        logic [5:0] rows;
        logic [7:0] tab;
        logic       scroll;
        logic       no_wrap;
        logic       hide;
    } t_cfg;

    typedef struct packed {
        logic clearing;
        logic busy;
    } t_ctl_stat;

endpackage

// ----- rtl/core/twcw_if.sv -----
// Request and result channel interfaces of the text window writer.
// Depends on nothing; widths follow the fixed command and result fields.
interface twcw_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [6:0] ch;
    logic [4:0] row;
    logic [6:0] col;
    modport source (output valid, cmd, ch, row, col, input ready);
    modport sink   (input valid, cmd, ch, row, col, output ready);
endinterface

interface twcw_res_if;
    logic              valid;
    logic              ready;
    logic              status;
    logic signed [5:0] cursor_row;
    logic signed [7:0] cursor_col;
    logic        [6:0] cell_data;
    logic              full_res;
    modport source (output valid, status, cursor_row, cursor_col, cell_data, full_res,
                    input ready);
    modport sink   (input valid, status, cursor_row, cursor_col, cell_data, full_res,
                    output ready);
endinterface

// ----- rtl/core/twcw_store.sv -----
// Character cell memory: one write port, one read port, registered read data.
// No package dependency; the address is {row, column}.
module twcw_store #(
    parameter int ADDR_W = 12
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [6:0]        i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [6:0]        o_rdata
);
    logic [6:0] mem [2**ADDR_W];
    logic [6:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/core/twcw_ctrl.sv -----
// Command sequencer: runs writes, tabs, newlines, scrolls, clears and reads
// against the cell memory and holds the result register. Uses twcw_pkg, the
// channel interfaces and twcw_store.
module twcw_ctrl #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  twcw_pkg::t_cfg     i_cfg,
    twcw_req_if.sink           i_req,
    twcw_res_if.source         o_res,
    output twcw_pkg::t_ctl_stat o_stat
);
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW     = ROW_W + COL_W;
    localparam int COLC_W = $clog2(MAX_COLS + 1);
    localparam int ROWC_W = $clog2(MAX_ROWS + 1);
    localparam int TN_W   = $clog2(MAX_COLS + 257);

    twcw_pkg::t_state r_state, n_state;
    twcw_pkg::t_cont  r_cont, n_cont, scont;

    logic [ROW_W-1:0]  r_row, n_row, r_br, n_br, r_sr, n_sr, sat_row;
    logic [COLC_W-1:0] r_col, n_col, r_bc, n_bc, r_sc, n_sc, sat_col;
    logic              r_full, n_full, r_status, n_status;
    logic [6:0]        r_cell, n_cell, r_glyph, n_glyph, r_ch2, n_ch2;
    logic              r_second, n_second, r_tab, n_tab;
    logic [TN_W-1:0]   r_tn, n_tn, r_tp, n_tp;
    logic [AW-1:0]     r_clr;

    logic              r_ov;
    logic              r_o_status, r_o_full;
    logic [5:0]        r_o_crow;
    logic [7:0]        r_o_ccol;
    logic [6:0]        r_o_cell;

    logic [COLC_W-1:0] wcols;
    logic [ROWC_W-1:0] wrows;
    logic [7:0]        tdist;
    logic [TN_W-1:0]   limit, p_in, p_inc, p_new, tn_new;

    logic accept, out_free, at_end, row_last, post_more, blank_act;
    logic sc_last, scr_last, win_more, in_range, is_ctl, scr_one;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [6:0]    mem_wdata, mem_rdata;

    twcw_store #(.ADDR_W(AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Window size after saturating the registers into the store.
    always_comb begin
        if (i_cfg.cols == 8'd0) wcols = COLC_W'(1);
        else if (32'(i_cfg.cols) > MAX_COLS) wcols = COLC_W'(MAX_COLS);
        else wcols = COLC_W'(i_cfg.cols);
        if (i_cfg.rows == 6'd0) wrows = ROWC_W'(1);
        else if (32'(i_cfg.rows) > MAX_ROWS) wrows = ROWC_W'(MAX_ROWS);
        else wrows = ROWC_W'(i_cfg.rows);
        tdist = (i_cfg.tab == 8'd0) ? 8'd1 : i_cfg.tab;
    end

    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_ov || o_res.ready;
    assign sat_row  = (32'(r_row) >= 32'(wrows)) ? ROW_W'(32'(wrows) - 1) : r_row;
    assign sat_col  = (32'(r_col) > 32'(wcols)) ? wcols : r_col;
    assign at_end   = 32'(r_col) >= 32'(wcols);
    assign row_last = 32'(r_row) + 32'd1 >= 32'(wrows);
    assign scr_one  = (wrows == ROWC_W'(1));
    assign limit    = TN_W'(wcols) + TN_W'(tdist);
    assign p_in     = at_end ? '0 : r_tp;
    assign p_inc    = p_in + TN_W'(1);
    assign p_new    = (p_inc == TN_W'(tdist)) ? '0 : p_inc;
    assign tn_new   = r_tn + TN_W'(1);
    assign post_more = r_tab ? ((p_new != '0) && (tn_new < limit)) : r_second;
    assign blank_act = 32'(r_bc) < 32'(wcols);
    assign sc_last  = 32'(r_sc) + 32'd1 >= 32'(wcols);
    assign scr_last = sc_last && (32'(r_sr) + 32'd2 >= 32'(wrows));
    assign win_more = 32'(r_br) + 32'd1 < 32'(wrows);
    assign in_range = (32'(i_req.row) < MAX_ROWS) && (32'(i_req.col) < MAX_COLS);
    assign is_ctl   = (i_req.ch < twcw_pkg::CH_SPACE) || (i_req.ch == twcw_pkg::CH_DEL);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            twcw_pkg::ST_CLEAR: if (&r_clr) n_state = twcw_pkg::ST_IDLE;
            twcw_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_req.cmd)
                        twcw_pkg::CMD_WRITE: begin
                            if (r_full) n_state = twcw_pkg::ST_DONE;
                            else if (i_req.ch == twcw_pkg::CH_NL)
                                n_state = (32'(sat_col) < 32'(wcols)) ?
                                          twcw_pkg::ST_BLANK : twcw_pkg::ST_NL;
                            else if (i_req.ch == twcw_pkg::CH_TAB) n_state = twcw_pkg::ST_TMOD;
                            else if (i_req.ch == twcw_pkg::CH_BS || i_req.ch == twcw_pkg::CH_CR)
                                n_state = twcw_pkg::ST_DONE;
                            else if (is_ctl && i_cfg.hide) n_state = twcw_pkg::ST_DONE;
                            else n_state = twcw_pkg::ST_GLYPH;
                        end
                        twcw_pkg::CMD_CLRL, twcw_pkg::CMD_CLRW:
                            n_state = r_full ? twcw_pkg::ST_DONE : twcw_pkg::ST_BLANK;
                        twcw_pkg::CMD_READ:
                            n_state = in_range ? twcw_pkg::ST_READ : twcw_pkg::ST_DONE;
                        default: n_state = twcw_pkg::ST_DONE;
                    endcase
                end
            end
            twcw_pkg::ST_NL: begin
                if (row_last && i_cfg.scroll)
                    n_state = scr_one ? twcw_pkg::ST_BLANK : twcw_pkg::ST_SCR_RD;
                else n_state = twcw_pkg::ST_DONE;
            end
            twcw_pkg::ST_GLYPH: begin
                if (at_end && i_cfg.no_wrap) n_state = twcw_pkg::ST_DONE;
                else if (at_end && row_last)
                    n_state = !i_cfg.scroll ? twcw_pkg::ST_DONE :
                              (scr_one ? twcw_pkg::ST_BLANK : twcw_pkg::ST_SCR_RD);
                else n_state = post_more ? twcw_pkg::ST_GLYPH : twcw_pkg::ST_DONE;
            end
            twcw_pkg::ST_TMOD:
                if (r_tp < TN_W'(tdist)) n_state = twcw_pkg::ST_GLYPH;
            twcw_pkg::ST_SCR_RD: n_state = twcw_pkg::ST_SCR_WR;
            twcw_pkg::ST_SCR_WR:
                n_state = scr_last ? twcw_pkg::ST_BLANK : twcw_pkg::ST_SCR_RD;
            twcw_pkg::ST_BLANK: begin
                if (!blank_act) begin
                    case (r_cont)
                        twcw_pkg::CT_NL:     n_state = twcw_pkg::ST_NL;
                        twcw_pkg::CT_WIN:
                            n_state = win_more ? twcw_pkg::ST_BLANK : twcw_pkg::ST_DONE;
                        twcw_pkg::CT_SCR_GL: n_state = twcw_pkg::ST_GLYPH;
                        default:             n_state = twcw_pkg::ST_DONE;
                    endcase
                end
            end
            twcw_pkg::ST_READ: n_state = twcw_pkg::ST_DONE;
            twcw_pkg::ST_DONE: if (out_free) n_state = twcw_pkg::ST_IDLE;
            default: n_state = twcw_pkg::ST_IDLE;
        endcase
    end

    // Datapath next values.
    always_comb begin
        n_row = r_row; n_col = r_col; n_full = r_full; n_status = r_status;
        n_cell = r_cell; n_glyph = r_glyph; n_ch2 = r_ch2; n_second = r_second;
        n_tab = r_tab; n_tn = r_tn; n_tp = r_tp; n_cont = r_cont;
        n_br = r_br; n_bc = r_bc; n_sr = r_sr; n_sc = r_sc;
        scont = (r_state == twcw_pkg::ST_NL) ? twcw_pkg::CT_SCR_NL : twcw_pkg::CT_SCR_GL;
        case (r_state)
            twcw_pkg::ST_IDLE: begin
                if (accept) begin
                    n_row = sat_row; n_col = sat_col;
                    n_status = 1'b0; n_cell = '0;
                    n_tab = 1'b0; n_second = 1'b0;
                    n_br = sat_row; n_bc = sat_col; n_cont = twcw_pkg::CT_DONE;
                    case (i_req.cmd)
                        twcw_pkg::CMD_WRITE: begin
                            if (r_full) n_status = 1'b1;
                            else if (i_req.ch == twcw_pkg::CH_NL) n_cont = twcw_pkg::CT_NL;
                            else if (i_req.ch == twcw_pkg::CH_TAB) begin
                                n_tab = 1'b1; n_tn = '0; n_tp = TN_W'(sat_col);
                                n_glyph = twcw_pkg::CH_SPACE;
                            end else if (i_req.ch == twcw_pkg::CH_BS) begin
                                if (sat_col != '0) n_col = sat_col - COLC_W'(1);
                            end else if (i_req.ch == twcw_pkg::CH_CR) n_col = '0;
                            else if (is_ctl) begin
                                n_glyph = twcw_pkg::CH_CARET; n_second = 1'b1;
                                n_ch2 = (i_req.ch == twcw_pkg::CH_DEL) ? twcw_pkg::CH_QMARK :
                                        i_req.ch + twcw_pkg::CH_AT;
                            end else n_glyph = i_req.ch;
                        end
                        twcw_pkg::CMD_HOME: begin
                            n_row = '0; n_col = '0; n_full = 1'b0;
                        end
                        twcw_pkg::CMD_CLRL: if (r_full) n_status = 1'b1;
                        twcw_pkg::CMD_CLRW: begin
                            if (r_full) n_status = 1'b1;
                            n_cont = twcw_pkg::CT_WIN;
                        end
                        default: ;
                    endcase
                end
            end
            twcw_pkg::ST_NL: begin
                n_col = '0;
                if (row_last) begin
                    if (!i_cfg.scroll) begin
                        n_full = 1'b1; n_status = 1'b1;
                    end else begin
                        n_row = ROW_W'(32'(wrows) - 1); n_sr = '0; n_sc = '0;
                        n_br = ROW_W'(32'(wrows) - 1); n_bc = '0; n_cont = scont;
                    end
                end else n_row = r_row + ROW_W'(1);
            end
            twcw_pkg::ST_GLYPH: begin
                if ((at_end && i_cfg.no_wrap) || (at_end && row_last && !i_cfg.scroll))
                    n_status = 1'b1;
                else if (at_end && row_last) begin
                    n_row = ROW_W'(32'(wrows) - 1); n_sr = '0; n_sc = '0;
                    n_br = ROW_W'(32'(wrows) - 1); n_bc = '0; n_cont = scont;
                end else begin
                    if (at_end) begin
                        n_row = r_row + ROW_W'(1);
                        n_col = COLC_W'(1);
                    end else n_col = r_col + COLC_W'(1);
                    if (r_tab) begin
                        n_tp = p_new; n_tn = tn_new;
                    end else if (r_second) begin
                        n_glyph = r_ch2; n_second = 1'b0;
                    end
                end
            end
            twcw_pkg::ST_TMOD: if (r_tp >= TN_W'(tdist)) n_tp = r_tp - TN_W'(tdist);
            twcw_pkg::ST_SCR_WR: begin
                if (sc_last) begin
                    n_sc = '0; n_sr = r_sr + ROW_W'(1);
                end else n_sc = r_sc + COLC_W'(1);
            end
            twcw_pkg::ST_BLANK: begin
                if (blank_act) n_bc = r_bc + COLC_W'(1);
                else begin
                    case (r_cont)
                        twcw_pkg::CT_WIN: if (win_more) begin
                            n_br = r_br + ROW_W'(1); n_bc = '0;
                        end
                        twcw_pkg::CT_SCR_NL: n_col = '0;
                        twcw_pkg::CT_SCR_GL: begin
                            n_col = '0; n_tp = '0;
                        end
                        default: ;
                    endcase
                end
            end
            twcw_pkg::ST_READ: n_cell = mem_rdata;
            default: ;
        endcase
    end

    // Memory drive and handshake outputs.
    always_comb begin
        mem_we = 1'b0; mem_waddr = '0; mem_wdata = twcw_pkg::CH_SPACE;
        mem_re = 1'b0; mem_raddr = {ROW_W'(i_req.row), COL_W'(i_req.col)};
        case (r_state)
            twcw_pkg::ST_CLEAR: begin
                mem_we = 1'b1; mem_waddr = r_clr;
            end
            twcw_pkg::ST_IDLE: mem_re = accept && (i_req.cmd == twcw_pkg::CMD_READ) && in_range;
            twcw_pkg::ST_GLYPH: begin
                mem_we = !at_end || (!i_cfg.no_wrap && !row_last);
                mem_wdata = r_glyph;
                mem_waddr = at_end ? {r_row + ROW_W'(1), COL_W'(0)} :
                                     {r_row, COL_W'(r_col)};
            end
            twcw_pkg::ST_SCR_RD: begin
                mem_re = 1'b1;
                mem_raddr = {r_sr + ROW_W'(1), COL_W'(r_sc)};
            end
            twcw_pkg::ST_SCR_WR: begin
                mem_we = 1'b1; mem_waddr = {r_sr, COL_W'(r_sc)}; mem_wdata = mem_rdata;
            end
            twcw_pkg::ST_BLANK: begin
                mem_we = blank_act; mem_waddr = {r_br, COL_W'(r_bc)};
            end
            default: ;
        endcase
    end

    assign i_req.ready     = (r_state == twcw_pkg::ST_IDLE);
    assign o_stat.clearing = (r_state == twcw_pkg::ST_CLEAR);
    assign o_stat.busy     = (r_state != twcw_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= twcw_pkg::ST_CLEAR;
            r_clr <= '0;
            r_row <= '0; r_col <= '0; r_full <= 1'b0;
            r_ov <= 1'b0;
            r_tab <= 1'b0; r_second <= 1'b0;
            r_cont <= twcw_pkg::CT_DONE;
        end else begin
            r_state <= n_state;
            r_clr <= r_clr + AW'(1);
            r_row <= n_row; r_col <= n_col; r_full <= n_full;
            r_tab <= n_tab; r_second <= n_second; r_cont <= n_cont;
            if (r_state == twcw_pkg::ST_DONE && out_free) r_ov <= 1'b1;
            else if (o_res.ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status; r_cell <= n_cell; r_glyph <= n_glyph; r_ch2 <= n_ch2;
        r_tn <= n_tn; r_tp <= n_tp; r_br <= n_br; r_bc <= n_bc;
        r_sr <= n_sr; r_sc <= n_sc;
        if (r_state == twcw_pkg::ST_DONE && out_free) begin
            r_o_status <= r_status;
            r_o_full <= r_full;
            r_o_cell <= r_cell;
            r_o_crow <= r_full ? 6'h3F : 6'(r_row);
            if (r_full) r_o_ccol <= 8'hFF;
            else if (!at_end) r_o_ccol <= 8'(r_col);
            else r_o_ccol <= i_cfg.no_wrap ? 8'hFF : 8'h00;
        end
    end

    assign o_res.valid      = r_ov;
    assign o_res.status     = r_o_status;
    assign o_res.cursor_row = $signed(r_o_crow);
    assign o_res.cursor_col = $signed(r_o_ccol);
    assign o_res.cell_data  = r_o_cell;
    assign o_res.full_res   = r_o_full;
endmodule

// ----- rtl/core/text_window_char_writer.sv -----
// Top level of the text window character writer: configuration registers,
// sequencer and checks. Uses twcw_pkg, the channel interfaces and twcw_ctrl.
//
//   channel   direction  carries
//   i_req     in         cmd, ch, row, col
//   o_res     out        status, cursor_row, cursor_col, cell_data, full_res
//   i_cfg_*   in         register writes, no handshake
//
// A plain character is accepted, written to its cell and then loaded into
// the result. Line clear writes one space per cleared cell, a newline first
// clears the rest of its row, a scroll reads and then writes each moved cell
// and adds one row of blanks, and a tab finds its phase by subtracting
// tab_size from col, then writes its spaces.
// After reset a clearing pass over MAX_ROWS*MAX_COLS cells (power-of-two
// rounded, 4096 by default) fills the memory with spaces before a request
// is taken. A waiting result stalls only the final state, holding off the next request.
module text_window_char_writer #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    twcw_req_if.sink   i_req,
    twcw_res_if.source o_res
);
    twcw_pkg::t_cfg      r_cfg;
    twcw_pkg::t_ctl_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cols    <= 8'd80;
            r_cfg.rows    <= 6'd24;
            r_cfg.tab     <= 8'd8;
            r_cfg.scroll  <= 1'b0;
            r_cfg.no_wrap <= 1'b0;
            r_cfg.hide    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                twcw_pkg::CFG_COLS:   r_cfg.cols    <= i_cfg_data;
                twcw_pkg::CFG_ROWS:   r_cfg.rows    <= i_cfg_data[5:0];
                twcw_pkg::CFG_TAB:    r_cfg.tab     <= i_cfg_data;
                twcw_pkg::CFG_SCROLL: r_cfg.scroll  <= i_cfg_data[0];
                twcw_pkg::CFG_NOWRAP: r_cfg.no_wrap <= i_cfg_data[0];
                twcw_pkg::CFG_HIDE:   r_cfg.hide    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    twcw_ctrl #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_req   (i_req),
        .o_res   (o_res),
        .o_stat  (stat)
    );

    // One request in flight: an accepted request drops ready at once.
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("request taken while another is in flight");

    a_clear_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.clearing |-> !i_req.ready)
        else $error("request taken during the clearing pass");

    a_full_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.full_res |->
            o_res.cursor_row == -6'sd1 && o_res.cursor_col == -8'sd1)
        else $error("full window reported with a live cursor");

    a_busy_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !stat.busy)
        else $error("ready raised while the sequencer is busy");
endmodule
